FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the I2C bit sequencer RTL.
// No dependencies; included by i2cm_core, the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// The expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/i2cm_pkg.sv
// Types, codes and constants of the I2C master bit sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cm_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_STOP_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PHASE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT     = 2'd2;

    localparam logic [7:0] RST_START_STOP_HOLD = 8'd5;
    localparam logic [7:0] RST_BIT_PHASE_TICKS = 8'd2;
    localparam logic [7:0] RST_ACK_TIMEOUT     = 8'd250;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_ST_HIGH   = 4'd1;
    localparam logic [3:0] PH_ST_SDALOW = 4'd2;
    localparam logic [3:0] PH_SP_LOW    = 4'd3;
    localparam logic [3:0] PH_SP_HIGH   = 4'd4;
    localparam logic [3:0] PH_WR_LOW    = 4'd5;
    localparam logic [3:0] PH_WR_HIGH   = 4'd6;
    localparam logic [3:0] PH_WR_TAIL   = 4'd7;
    localparam logic [3:0] PH_AK_HOLD   = 4'd8;
    localparam logic [3:0] PH_AK_WAIT   = 4'd9;
    localparam logic [3:0] PH_RD_LOW    = 4'd10;
    localparam logic [3:0] PH_RD_HIGH   = 4'd11;
    localparam logic [3:0] PH_RA_LOW    = 4'd12;
    localparam logic [3:0] PH_RA_HIGH   = 4'd13;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [7:0] start_stop_hold;
        logic [7:0] bit_phase_ticks;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_result;

    function automatic logic [7:0] eff_hold(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer top level: ticks in, one status word out per tick.
// Instantiates i2cm_cfg and i2cm_core; depends on i2cm_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): each accepted word is one bus tick with
//   the sampled SDA level; while idle the word may also launch a start, stop,
//   byte write or byte read command.
//   Output channel (o_valid / i_stall): exactly one status word per accepted
//   tick, carrying SCL and SDA drive levels, busy, done, the last received
//   byte and the ACK error flag after that tick.
//   Configuration channel (i_cfg_valid / o_cfg_ready): writes the start/stop
//   hold, bit phase and ACK timeout registers; ready is always high. Write
//   only while no command is running.
// Timing:
//   The output word is registered and appears in the cycle after input acceptance.
//   One tick is accepted every cycle while o_stall is low; the state machine
//   update sits between the state registers and the output register.
// Reset and flow control:
//   Reset releases both lines, returns to idle and loads register defaults.
//   o_stall rises only when the output word is held and i_stall is high.
`default_nettype none

module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [2:0]           i_cmd,
    input  wire logic [7:0]           i_tx_byte,
    input  wire logic                 i_send_ack,
    input  wire logic                 i_sda_in,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_scl_level,
    output logic                      o_sda_release,
    output logic                      o_busy_res,
    output logic                      o_done_res,
    output logic [7:0]                o_rx_byte,
    output logic                      o_ack_error,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_cfg    cfg;
    t_item   item;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;

    assign item.cmd      = i_cmd;
    assign item.tx_byte  = i_tx_byte;
    assign item.send_ack = i_send_ack;
    assign item.sda_in   = i_sda_in;

    i2cm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    i2cm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_scl_level   = r_out.scl_level;
    assign o_sda_release = r_out.sda_release;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_rx_byte     = r_out.rx_byte;
    assign o_ack_error   = r_out.ack_error;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_cfg.sv
// Configuration register file of the I2C master bit sequencer.
// Depends on i2cm_pkg for register indexes and reset values.
`default_nettype none

module i2cm_cfg
    import i2cm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [7:0]           i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_stop_hold <= RST_START_STOP_HOLD;
            r_cfg.bit_phase_ticks <= RST_BIT_PHASE_TICKS;
            r_cfg.ack_timeout     <= RST_ACK_TIMEOUT;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_START_STOP_HOLD: r_cfg.start_stop_hold <= i_wr_data;
                REG_BIT_PHASE_TICKS: r_cfg.bit_phase_ticks <= i_wr_data;
                REG_ACK_TIMEOUT:     r_cfg.ack_timeout     <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_core.sv
// Bus phase state machine of the I2C master bit sequencer: one tick per word.
// Depends on i2cm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cm_core
    import i2cm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    logic [3:0] r_phase, n_phase;
    logic [3:0] r_bit_index, n_bit_index;
    logic [7:0] r_hold, n_hold;
    logic [7:0] r_wait, n_wait;
    logic [7:0] r_shift, n_shift;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_ack_mode, n_ack_mode;
    logic [7:0] r_rx, n_rx;
    logic       r_err, n_err;
    logic       done;
    logic [7:0] ss_hold;
    logic [7:0] bit_hold;
    logic [7:0] shifted;
    logic       ack_seen;
    logic       hold_free;

    assign ss_hold  = eff_hold(i_cfg.start_stop_hold);
    assign bit_hold = eff_hold(i_cfg.bit_phase_ticks);
    assign shifted  = {r_shift[6:0], 1'b0};

    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_hold      = r_hold;
        n_wait      = r_wait;
        n_shift     = r_shift;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack_mode  = r_ack_mode;
        n_rx        = r_rx;
        n_err       = r_err;
        done        = 1'b0;
        if (r_phase == PH_IDLE) begin
            unique case (i_item.cmd)
                CMD_START: begin
                    n_phase = PH_ST_HIGH; n_scl = 1'b1; n_sda = 1'b1; n_hold = ss_hold;
                end
                CMD_STOP: begin
                    n_phase = PH_SP_LOW; n_scl = 1'b0; n_sda = 1'b0; n_hold = ss_hold;
                end
                CMD_WRITE: begin
                    n_shift     = i_item.tx_byte;
                    n_bit_index = 4'd0;
                    n_phase     = PH_WR_LOW;
                    n_scl       = 1'b0;
                    n_sda       = i_item.tx_byte[7];
                    n_hold      = bit_hold;
                end
                CMD_READ: begin
                    n_shift     = 8'd0;
                    n_bit_index = 4'd0;
                    n_ack_mode  = i_item.send_ack;
                    n_phase     = PH_RD_LOW;
                    n_scl       = 1'b0;
                    n_sda       = 1'b1;
                    n_hold      = bit_hold;
                end
                default: ;
            endcase
        end else if (r_phase == PH_AK_WAIT) begin
            if (!i_item.sda_in) begin
                n_scl   = 1'b0;
                n_err   = 1'b0;
                n_phase = PH_IDLE;
                done    = 1'b1;
            end else if (r_wait >= i_cfg.ack_timeout) begin
                n_err   = 1'b1;
                n_phase = PH_SP_LOW;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_hold  = ss_hold;
            end else begin
                n_wait = r_wait + 8'd1;
            end
        end else if (r_hold > 8'd1) begin
            n_hold = r_hold - 8'd1;
        end else begin
            unique case (r_phase)
                PH_ST_HIGH: begin
                    n_phase = PH_ST_SDALOW; n_scl = 1'b1; n_sda = 1'b0; n_hold = ss_hold;
                end
                PH_ST_SDALOW: begin
                    n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                end
                PH_SP_LOW: begin
                    n_phase = PH_SP_HIGH; n_scl = 1'b1; n_sda = 1'b1; n_hold = ss_hold;
                end
                PH_SP_HIGH: begin
                    n_phase = PH_IDLE; done = 1'b1;
                end
                PH_WR_LOW: begin
                    n_phase = PH_WR_HIGH; n_scl = 1'b1; n_hold = bit_hold;
                end
                PH_WR_HIGH: begin
                    n_phase = PH_WR_TAIL; n_scl = 1'b0; n_hold = bit_hold;
                end
                PH_WR_TAIL: begin
                    n_shift     = shifted;
                    n_bit_index = r_bit_index + 4'd1;
                    if (n_bit_index < BITS_PER_BYTE) begin
                        n_phase = PH_WR_LOW; n_scl = 1'b0; n_sda = shifted[7];
                        n_hold  = bit_hold;
                    end else begin
                        n_phase = PH_AK_HOLD; n_scl = 1'b1; n_sda = 1'b1;
                        n_hold  = ss_hold;
                    end
                end
                PH_AK_HOLD: begin
                    n_wait  = 8'd0;
                    n_phase = PH_AK_WAIT;
                end
                PH_RD_LOW: begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_phase = PH_RD_HIGH; n_scl = 1'b1; n_sda = 1'b1; n_hold = bit_hold;
                end
                PH_RD_HIGH: begin
                    n_bit_index = r_bit_index + 4'd1;
                    n_scl       = 1'b0;
                    n_hold      = bit_hold;
                    if (n_bit_index < BITS_PER_BYTE) begin
                        n_phase = PH_RD_LOW; n_sda = 1'b1;
                    end else begin
                        n_rx    = r_shift;
                        n_phase = PH_RA_LOW; n_sda = !r_ack_mode;
                    end
                end
                PH_RA_LOW: begin
                    n_phase = PH_RA_HIGH; n_scl = 1'b1; n_hold = bit_hold;
                end
                PH_RA_HIGH: begin
                    n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_index <= 4'd0;
            r_hold      <= 8'd0;
            r_wait      <= 8'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack_mode  <= 1'b0;
            r_rx        <= 8'd0;
            r_err       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_index <= n_bit_index;
            r_hold      <= n_hold;
            r_wait      <= n_wait;
            r_shift     <= n_shift;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack_mode  <= n_ack_mode;
            r_rx        <= n_rx;
            r_err       <= n_err;
        end
    end

    assign o_res.scl_level   = n_scl;
    assign o_res.sda_release = n_sda;
    assign o_res.busy_res    = (n_phase != PH_IDLE);
    assign o_res.done_res    = done;
    assign o_res.rx_byte     = n_rx;
    assign o_res.ack_error   = n_err;

    assign ack_seen  = i_step && (r_phase == PH_AK_WAIT) && !i_item.sda_in;
    assign hold_free = (r_phase == PH_IDLE) || (r_phase == PH_AK_WAIT);

    `ASSERT_NEXT(a_ack_ends_cmd, i_clk, i_rst_n, ack_seen, r_phase == PH_IDLE && !r_err)
    `ASSERT_ALWAYS(a_bit_index_range, i_clk, i_rst_n, r_bit_index <= BITS_PER_BYTE)
    `ASSERT_ALWAYS(a_hold_loaded, i_clk, i_rst_n, hold_free || r_hold != 8'd0)

endmodule

`default_nettype wire

FILE: bench/tb_i2c_master_bit_sequencer.sv
// Self-checking testbench for the I2C master bit sequencer.
// Drives bus ticks and register writes, predicts every status word in a scoreboard class.
// Depends on i2cm_pkg and the i2c_master_bit_sequencer RTL.
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer;
    import i2cm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    class bus_tick_scoreboard;
        t_cfg       cfg;
        logic [3:0] ph;
        logic [3:0] bit_cnt;
        logic [7:0] hold;
        logic [7:0] wait_cnt;
        logic [7:0] shreg;
        logic       scl;
        logic       sda;
        logic       ack_drv;
        logic [7:0] rx;
        logic       err;
        t_result    expected_status[$];
        int         errors;
        int         ticks;
        int         words_checked;
        int         launched;
        int         ack_timeouts;

        function new();
            cfg.start_stop_hold = RST_START_STOP_HOLD;
            cfg.bit_phase_ticks = RST_BIT_PHASE_TICKS;
            cfg.ack_timeout     = RST_ACK_TIMEOUT;
            ph       = PH_IDLE;
            bit_cnt  = '0;
            hold     = '0;
            wait_cnt = '0;
            shreg    = '0;
            scl      = 1'b1;
            sda      = 1'b1;
            ack_drv  = 1'b0;
            rx       = '0;
            err      = 1'b0;
        endfunction

        function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                REG_START_STOP_HOLD: cfg.start_stop_hold = data;
                REG_BIT_PHASE_TICKS: cfg.bit_phase_ticks = data;
                REG_ACK_TIMEOUT:     cfg.ack_timeout     = data;
                default: ;
            endcase
        endfunction

        function void enter(logic [3:0] nph, logic nscl, logic nsda, logic [7:0] h);
            ph   = nph;
            scl  = nscl;
            sda  = nsda;
            hold = (h == 8'd0) ? 8'd1 : h;
        endfunction

        function bit idle();
            return ph == PH_IDLE;
        endfunction

        function bit awaiting_ack();
            return (ph == PH_AK_HOLD) || (ph == PH_AK_WAIT);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_tick(t_item it);
            logic    done;
            t_result r;
            done = 1'b0;
            ticks++;
            if (ph == PH_IDLE) begin
                case (it.cmd)
                    CMD_START: begin
                        launched++;
                        enter(PH_ST_HIGH, 1'b1, 1'b1, cfg.start_stop_hold);
                    end
                    CMD_STOP: begin
                        launched++;
                        enter(PH_SP_LOW, 1'b0, 1'b0, cfg.start_stop_hold);
                    end
                    CMD_WRITE: begin
                        launched++;
                        shreg   = it.tx_byte;
                        bit_cnt = '0;
                        enter(PH_WR_LOW, 1'b0, shreg[7], cfg.bit_phase_ticks);
                    end
                    CMD_READ: begin
                        launched++;
                        shreg   = '0;
                        bit_cnt = '0;
                        ack_drv = it.send_ack;
                        enter(PH_RD_LOW, 1'b0, 1'b1, cfg.bit_phase_ticks);
                    end
                    default: ;
                endcase
            end else if (ph == PH_AK_WAIT) begin
                if (!it.sda_in) begin
                    scl  = 1'b0;
                    err  = 1'b0;
                    ph   = PH_IDLE;
                    done = 1'b1;
                end else if (wait_cnt >= cfg.ack_timeout) begin
                    err = 1'b1;
                    ack_timeouts++;
                    enter(PH_SP_LOW, 1'b0, 1'b0, cfg.start_stop_hold);
                end else begin
                    wait_cnt++;
                end
            end else if (hold > 8'd1) begin
                hold--;
            end else begin
                case (ph)
                    PH_ST_HIGH: enter(PH_ST_SDALOW, 1'b1, 1'b0, cfg.start_stop_hold);
                    PH_ST_SDALOW: begin
                        scl  = 1'b0;
                        ph   = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_SP_LOW: enter(PH_SP_HIGH, 1'b1, 1'b1, cfg.start_stop_hold);
                    PH_SP_HIGH: begin
                        ph   = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_WR_LOW:  enter(PH_WR_HIGH, 1'b1, sda, cfg.bit_phase_ticks);
                    PH_WR_HIGH: enter(PH_WR_TAIL, 1'b0, sda, cfg.bit_phase_ticks);
                    PH_WR_TAIL: begin
                        shreg   = shreg << 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            enter(PH_WR_LOW, 1'b0, shreg[7], cfg.bit_phase_ticks);
                        end else begin
                            enter(PH_AK_HOLD, 1'b1, 1'b1, cfg.start_stop_hold);
                        end
                    end
                    PH_AK_HOLD: begin
                        wait_cnt = '0;
                        ph       = PH_AK_WAIT;
                    end
                    PH_RD_LOW: begin
                        shreg = {shreg[6:0], it.sda_in};
                        enter(PH_RD_HIGH, 1'b1, 1'b1, cfg.bit_phase_ticks);
                    end
                    PH_RD_HIGH: begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            enter(PH_RD_LOW, 1'b0, 1'b1, cfg.bit_phase_ticks);
                        end else begin
                            rx = shreg;
                            enter(PH_RA_LOW, 1'b0, !ack_drv, cfg.bit_phase_ticks);
                        end
                    end
                    PH_RA_LOW: enter(PH_RA_HIGH, 1'b1, sda, cfg.bit_phase_ticks);
                    PH_RA_HIGH: begin
                        scl  = 1'b0;
                        ph   = PH_IDLE;
                        done = 1'b1;
                    end
                    default: ph = PH_IDLE;
                endcase
            end
            r.scl_level   = scl;
            r.sda_release = sda;
            r.busy_res    = (ph != PH_IDLE);
            r.done_res    = done;
            r.rx_byte     = rx;
            r.ack_error   = err;
            expected_status.push_back(r);
        endfunction

        function void compare(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_status.size() == 0) begin
                $error("status word arrived with none expected");
                errors++;
                return;
            end
            exp_r = expected_status.pop_front();
            words_checked++;
            compare("scl_level", 8'(exp_r.scl_level), 8'(got.scl_level));
            compare("sda_release", 8'(exp_r.sda_release), 8'(got.sda_release));
            compare("busy_res", 8'(exp_r.busy_res), 8'(got.busy_res));
            compare("done_res", 8'(exp_r.done_res), 8'(got.done_res));
            compare("rx_byte", exp_r.rx_byte, got.rx_byte);
            compare("ack_error", 8'(exp_r.ack_error), 8'(got.ack_error));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [2:0]           i_cmd;
    logic [7:0]           i_tx_byte;
    logic                 i_send_ack;
    logic                 i_sda_in;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_scl_level;
    logic                 o_sda_release;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [7:0]           o_rx_byte;
    logic                 o_ack_error;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    bus_tick_scoreboard sb = new();
    int src_idle_pct = 17;
    int snk_idle_pct = 54;
    int quiet_cycles = 0;

    i2c_master_bit_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_level   (o_scl_level),
        .o_sda_release (o_sda_release),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_ack_error   (o_ack_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_tick(t_item'{cmd: i_cmd, tx_byte: i_tx_byte,
                                     send_ack: i_send_ack, sda_in: i_sda_in});
            end
            if (o_valid && !i_stall) begin
                sb.check_result(t_result'{scl_level: o_scl_level,
                                          sda_release: o_sda_release,
                                          busy_res: o_busy_res, done_res: o_done_res,
                                          rx_byte: o_rx_byte, ack_error: o_ack_error});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_item pick_tick(logic [2:0] cmd, logic [7:0] tx, logic sack,
                                        bit nack);
        t_item it;
        it.cmd      = cmd;
        it.tx_byte  = tx;
        it.send_ack = sack;
        if (sb.awaiting_ack()) begin
            it.sda_in = nack ? 1'b1 : ($urandom_range(0, 9) >= 3);
        end else begin
            it.sda_in = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    function automatic logic [2:0] stray_cmd();
        return ($urandom_range(0, 9) < 2) ? 3'($urandom_range(0, 7)) : CMD_TICK;
    endfunction

    task automatic push_tick(t_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= it.cmd;
        i_tx_byte  <= it.tx_byte;
        i_send_ack <= it.send_ack;
        i_sda_in   <= it.sda_in;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_cfg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [7:0] ssh, logic [7:0] bpt, logic [7:0] ato,
                              bit touch_spare);
        drain();
        write_reg(REG_START_STOP_HOLD, ssh);
        write_reg(REG_BIT_PHASE_TICKS, bpt);
        write_reg(REG_ACK_TIMEOUT, ato);
        if (touch_spare) begin
            write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_cmd(logic [2:0] cmd, logic [7:0] tx, logic sack, bit nack);
        push_tick(pick_tick(cmd, tx, sack, nack));
        while (!sb.idle()) begin
            push_tick(pick_tick(stray_cmd(), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), nack));
        end
    endtask

    task automatic run_random(int n_cmds);
        int         r;
        logic [2:0] cmd;
        logic [2:0] filler;
        repeat (n_cmds) begin
            repeat ($urandom_range(0, 3)) begin
                filler = ($urandom_range(0, 3) == 0) ?
                         3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)) : CMD_TICK;
                push_tick(pick_tick(filler, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 1'b0));
            end
            r = $urandom_range(0, 9);
            if (r < 2) begin
                cmd = CMD_START;
            end else if (r < 4) begin
                cmd = CMD_STOP;
            end else if (r < 7) begin
                cmd = CMD_WRITE;
            end else begin
                cmd = CMD_READ;
            end
            run_cmd(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 6) == 0);
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_TICK;
        i_tx_byte   <= '0;
        i_send_ack  <= 1'b0;
        i_sda_in    <= 1'b1;
        i_stall     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_START_STOP_HOLD;
        i_cfg_data  <= '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_tick(pick_tick(CMD_TICK, 8'h00, 1'b0, 1'b0));
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'h00, 1'b1, 1'b0);
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, 1'b1);
        run_cmd(CMD_READ, 8'h00, 1'b1, 1'b0);
        run_cmd(CMD_READ, 8'hFF, 1'b0, 1'b0);
        run_cmd(CMD_STOP, 8'h5A, 1'b1, 1'b0);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
            push_tick(pick_tick(3'(c), 8'h3C, 1'b1, 1'b0));
        end
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'h80, 1'b0, 1'b0);
        run_cmd(CMD_READ, 8'h01, 1'b1, 1'b0);

        set_config(8'd1, 8'd1, 8'd3, 1'b0);
        run_random(6);

        src_idle_pct = 54;
        snk_idle_pct = 17;
        set_config(8'd0, 8'd0, 8'd0, 1'b1);
        run_random(6);
        set_config(8'd2, 8'd3, 8'd10, 1'b0);
        run_random(3);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(8'd1, 8'd1, 8'd255, 1'b0);
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
        run_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        run_cmd(CMD_READ, 8'h00, 1'b1, 1'b0);
        set_config(RST_START_STOP_HOLD, RST_BIT_PHASE_TICKS, RST_ACK_TIMEOUT, 1'b1);
        run_random(4);

        drain();
        repeat (10) @(negedge i_clk);
        $display("Ran %0d bus ticks with %0d commands launched and %0d ACK timeouts,",
                 sb.ticks, sb.launched, sb.ack_timeouts);
        $display("over six register settings; %0d status words checked, %0d mismatches.",
                 sb.words_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_cfg.sv
hw/rtl/i2cm_core.sv
hw/rtl/i2c_master_bit_sequencer.sv
bench/tb_i2c_master_bit_sequencer.sv
